// ===== rtl/svm_pkg.sv =====
// svm_pkg: shared codes, field widths and the limiter tanh table
// for the sample voice mixer; no dependencies
`timescale 1ns / 1ps

package svm_pkg;

    localparam int OP_W     = 3;
    localparam int CLIP_W   = 2;
    localparam int ADDR_W   = 17;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PITCH_W  = 17;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 72;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_TICK    = 3'd0;
    localparam t_op OP_START   = 3'd1;
    localparam t_op OP_WRITE   = 3'd2;
    localparam t_op OP_SETLOOP = 3'd3;
    localparam t_op OP_SILENCE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SHOT_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLAST_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP0_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP1_LEN  = 2'd3;

    // 0.9 in q0.16
    localparam logic [16:0] LIMIT_GAIN = 17'd58982;
    localparam logic [15:0] TANH_MAX   = 16'd32746;
    localparam logic [16:0] UNITY_RATE = 17'd65536;

    // tanh at steps of 0.25 over [0,4], q1.15
    function automatic logic [15:0] tanh_at(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:  v = 16'd0;
            4'd1:  v = 16'd8026;
            4'd2:  v = 16'd15143;
            4'd3:  v = 16'd20813;
            4'd4:  v = 16'd24956;
            4'd5:  v = 16'd27797;
            4'd6:  v = 16'd29660;
            4'd7:  v = 16'd30847;
            4'd8:  v = 16'd31589;
            4'd9:  v = 16'd32048;
            4'd10: v = 16'd32329;
            4'd11: v = 16'd32500;
            4'd12: v = 16'd32606;
            4'd13: v = 16'd32670;
            4'd14: v = 16'd32708;
            4'd15: v = 16'd32732;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // slope to the next table point
    function automatic logic [13:0] tanh_step(input logic [3:0] idx);
        logic [13:0] v;
        case (idx)
            4'd0:  v = 14'd8026;
            4'd1:  v = 14'd7117;
            4'd2:  v = 14'd5670;
            4'd3:  v = 14'd4143;
            4'd4:  v = 14'd2841;
            4'd5:  v = 14'd1863;
            4'd6:  v = 14'd1187;
            4'd7:  v = 14'd742;
            4'd8:  v = 14'd459;
            4'd9:  v = 14'd281;
            4'd10: v = 14'd171;
            4'd11: v = 14'd106;
            4'd12: v = 14'd64;
            4'd13: v = 14'd38;
            4'd14: v = 14'd24;
            4'd15: v = 14'd14;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sample_voice_mixer.sv =====
// sample_voice_mixer: clip memory, loop layers, voice table and limiter
// around one shared multiplier; depends on svm_pkg
`timescale 1ns / 1ps

// Usage
//   s_axis carries one command per transaction: tuser is the operation,
//   tdata the operands. Only a tick produces an m_axis transaction (the
//   mixed sample); clip writes, loop settings, silence and ignored codes
//   produce nothing.
//   Clip writes, set-loop and silence are handled in the idle state. A start
//   item scans the voice table one slot a cycle.
//   A tick walks every loop layer (an audible layer takes at most two wrap
//   steps) and every voice through the one multiplier and memory read
//   port, then the limiter steps and the output load.
//   s_axis_tready is high only while the sequencer is idle.
//   The sample waits in an output register; a tick may still be fully
//   computed during a stall and then waits for that register to empty.
//   Users write length registers via cfg port only while idle; unchecked.
//   Synchronous reset clears voices, loop cursors and gains, sets loop rates
//   to one; clip memory is not cleared and must be written before use.
module sample_voice_mixer #(
    parameter int VOICE_COUNT = 8,
    parameter int LOOP_LAYERS = 2,
    parameter int CLIP_DEPTH  = 131072
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [svm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [svm_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // clip_select, address, sample_value, gain, pitch, layer, zero pad
    input  logic [svm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic [svm_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mixed_sample
    output logic [15:0]                        m_axis_tdata
);
    import svm_pkg::*;

    localparam int LW     = $clog2(CLIP_DEPTH + 1);
    localparam int IW     = $clog2(CLIP_DEPTH);
    localparam int CW     = LW + 17;
    localparam int MEM_D  = 4 * CLIP_DEPTH;
    localparam int MEM_AW = $clog2(MEM_D);
    localparam int LLW    = (LOOP_LAYERS > 1) ? $clog2(LOOP_LAYERS) : 1;
    localparam int VCW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int PW     = 54;
    localparam int ACC_W  = PW + $clog2(LOOP_LAYERS + VOICE_COUNT + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LCHK  = 5'd1;
    localparam logic [4:0] ST_LRDA  = 5'd2;
    localparam logic [4:0] ST_LRDB  = 5'd3;
    localparam logic [4:0] ST_LMB   = 5'd4;
    localparam logic [4:0] ST_LSUM  = 5'd5;
    localparam logic [4:0] ST_LMG   = 5'd6;
    localparam logic [4:0] ST_LACC  = 5'd7;
    localparam logic [4:0] ST_LWRAP = 5'd8;
    localparam logic [4:0] ST_VCHK  = 5'd9;
    localparam logic [4:0] ST_VMUL  = 5'd10;
    localparam logic [4:0] ST_VACC  = 5'd11;
    localparam logic [4:0] ST_LM0   = 5'd12;
    localparam logic [4:0] ST_LM1   = 5'd13;
    localparam logic [4:0] ST_LM2   = 5'd14;
    localparam logic [4:0] ST_LM3   = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;
    localparam logic [4:0] ST_SCAN  = 5'd17;
    localparam logic [4:0] ST_VSET  = 5'd18;

    // input fields
    logic [CLIP_W-1:0]   w_clip;
    logic [ADDR_W-1:0]   w_addr;
    logic [SAMPLE_W-1:0] w_sample;
    logic [GAIN_W-1:0]   w_gain;
    logic [PITCH_W-1:0]  w_pitch;
    logic                w_layer;
    assign w_clip   = s_axis_tdata[1:0];
    assign w_addr   = s_axis_tdata[18:2];
    assign w_sample = s_axis_tdata[34:19];
    assign w_gain   = s_axis_tdata[50:35];
    assign w_pitch  = s_axis_tdata[67:51];
    assign w_layer  = s_axis_tdata[68];

    logic [4:0]              r_state, n_state;
    logic [LLW-1:0]          r_lyr, n_lyr;
    logic [VCW-1:0]          r_voice, n_voice;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [33:0]      r_tmp, n_tmp;
    logic [34:0]             r_x, n_x;
    logic                    r_neg, n_neg;
    logic                    r_sat, n_sat;
    logic [15:0]             r_lo, n_lo;
    logic [15:0]             r_res, n_res;
    logic signed [PW-1:0]    r_prod;
    logic signed [15:0]      r_rdata;
    logic [CFG_W-1:0]        r_len [4];
    logic [CW-1:0]           r_lcur [LOOP_LAYERS], n_lcur [LOOP_LAYERS];
    logic [GAIN_W-1:0]       r_lgain [LOOP_LAYERS], n_lgain [LOOP_LAYERS];
    logic [PITCH_W-1:0]      r_lrate [LOOP_LAYERS], n_lrate [LOOP_LAYERS];
    logic [VOICE_COUNT-1:0]  r_vact, n_vact;
    logic                    r_vclip [VOICE_COUNT], n_vclip [VOICE_COUNT];
    logic [LW-1:0]           r_vcur [VOICE_COUNT], n_vcur [VOICE_COUNT];
    logic [GAIN_W-1:0]       r_vgain [VOICE_COUNT], n_vgain [VOICE_COUNT];
    logic                    r_sclip, n_sclip;
    logic [GAIN_W-1:0]       r_sgain, n_sgain;
    logic                    r_found, n_found;
    logic [VCW-1:0]          r_pick, n_pick;
    logic [LW-1:0]           r_best, n_best;
    logic                    r_out_valid, n_out_valid;
    logic [15:0]             r_out_data, n_out_data;

    logic [15:0]             r_mem [MEM_D];

    logic                    w_in_acc;
    logic                    w_wr_en;
    logic [MEM_AW-1:0]       w_wr_addr;
    logic [MEM_AW-1:0]       w_rd_addr;
    logic signed [35:0]      w_mul_a;
    logic signed [17:0]      w_mul_b;
    logic signed [PW-1:0]    w_prod;
    logic [LW-1:0]           w_llen;
    logic [CW-1:0]           w_span;
    logic [IW-1:0]           w_lidx;
    logic [IW-1:0]           w_lnxt;
    logic [15:0]             w_frac;
    logic [1:0]              w_lclip;
    logic [LW-1:0]           w_vlen;
    logic [ACC_W-1:0]        w_mag;
    logic [34:0]             w_m;
    logic [15:0]             w_y;

    function automatic logic [LW-1:0] clip_len(input logic [CFG_W-1:0] v);
        return ({1'b0, v} > 19'(CLIP_DEPTH)) ? LW'(CLIP_DEPTH) : LW'(v);
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic [1:0] c,
                                                   input logic [IW-1:0] idx);
        return MEM_AW'(c) * MEM_AW'(CLIP_DEPTH) + MEM_AW'(idx);
    endfunction

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // current loop layer geometry
    assign w_lclip = 2'(32'd2 + 32'(r_lyr));
    assign w_llen  = (32'(r_lyr) < 2) ? clip_len(r_len[w_lclip]) : '0;
    assign w_span  = CW'(w_llen) << 16;
    assign w_lidx  = r_lcur[r_lyr][16 +: IW];
    assign w_lnxt  = ((LW'(w_lidx) + LW'(1)) < w_llen) ? IW'(w_lidx + IW'(1)) : '0;
    assign w_frac  = r_lcur[r_lyr][15:0];
    assign w_vlen  = clip_len(r_len[{1'b0, r_vclip[r_voice]}]);

    assign w_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    // a magnitude at or above 2^51 saturates the limiter anyway
    assign w_m   = (|w_mag[ACC_W-1:51]) ? '1 : w_mag[50:16];
    assign w_y   = r_sat ? r_lo : 16'(r_lo + 16'(r_prod[42:29]));

    assign w_wr_en   = w_in_acc && (s_axis_tuser == OP_WRITE)
                       && ({1'b0, w_addr} < 19'(CLIP_DEPTH));
    assign w_wr_addr = mem_addr(w_clip, IW'(w_addr));

    // full-width signed product of the shared multiplier
    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        unique case (r_state)
            ST_LRDB: w_rd_addr = mem_addr(w_lclip, w_lnxt);
            ST_VCHK: w_rd_addr = mem_addr({1'b0, r_vclip[r_voice]}, r_vcur[r_voice][IW-1:0]);
            default: w_rd_addr = mem_addr(w_lclip, w_lidx);
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_LRDB: begin
                w_mul_a = 36'(r_rdata);
                w_mul_b = 18'(17'h10000 - 17'(w_frac));
            end
            ST_LMB: begin
                w_mul_a = 36'(r_rdata);
                w_mul_b = 18'(w_frac);
            end
            ST_LMG: begin
                w_mul_a = 36'(r_tmp);
                w_mul_b = 18'(r_lgain[r_lyr]);
            end
            ST_VMUL: begin
                w_mul_a = 36'(r_rdata);
                w_mul_b = 18'(r_vgain[r_voice]);
            end
            ST_LM0: begin
                w_mul_a = 36'(w_m);
                w_mul_b = 18'(LIMIT_GAIN);
            end
            ST_LM2: begin
                w_mul_a = 36'(r_x[28:0]);
                w_mul_b = 18'(tanh_step(r_x[32:29]));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_lyr       = r_lyr;
        n_voice     = r_voice;
        n_acc       = r_acc;
        n_tmp       = r_tmp;
        n_x         = r_x;
        n_neg       = r_neg;
        n_sat       = r_sat;
        n_lo        = r_lo;
        n_res       = r_res;
        n_lcur      = r_lcur;
        n_lgain     = r_lgain;
        n_lrate     = r_lrate;
        n_vact      = r_vact;
        n_vclip     = r_vclip;
        n_vcur      = r_vcur;
        n_vgain     = r_vgain;
        n_sclip     = r_sclip;
        n_sgain     = r_sgain;
        n_found     = r_found;
        n_pick      = r_pick;
        n_best      = r_best;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (s_axis_tuser)
                        OP_TICK: begin
                            n_acc   = '0;
                            n_lyr   = '0;
                            n_state = ST_LCHK;
                        end
                        OP_START: begin
                            if (!w_clip[1]) begin
                                n_sclip = w_clip[0];
                                n_sgain = w_gain;
                                n_found = 1'b0;
                                n_best  = '0;
                                n_pick  = '0;
                                n_voice = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        OP_SETLOOP: begin
                            if (32'(w_layer) < LOOP_LAYERS) begin
                                n_lgain[LLW'(w_layer)] = w_gain;
                                n_lrate[LLW'(w_layer)] = w_pitch;
                            end
                        end
                        OP_SILENCE: begin
                            n_vact = '0;
                            for (int l = 0; l < LOOP_LAYERS; l++) n_lgain[l] = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LCHK: begin
                if (w_llen == '0) begin
                    if (32'(r_lyr) == LOOP_LAYERS - 1) begin
                        n_voice = '0;
                        n_state = ST_VCHK;
                    end else begin
                        n_lyr = LLW'(r_lyr + LLW'(1));
                    end
                end else begin
                    // length was lowered under the cursor
                    if (r_lcur[r_lyr] >= w_span) n_lcur[r_lyr] = '0;
                    n_state = ST_LRDA;
                end
            end
            ST_LRDA: n_state = ST_LRDB;
            ST_LRDB: n_state = ST_LMB;
            ST_LMB: begin
                n_tmp   = r_prod[33:0];
                n_state = ST_LSUM;
            end
            ST_LSUM: begin
                n_tmp   = 34'(r_tmp + r_prod[33:0]);
                n_state = ST_LMG;
            end
            ST_LMG: n_state = ST_LACC;
            ST_LACC: begin
                n_acc         = ACC_W'(r_acc + ACC_W'(r_prod));
                n_lcur[r_lyr] = CW'(r_lcur[r_lyr] + CW'(r_lrate[r_lyr]));
                n_state       = ST_LWRAP;
            end
            ST_LWRAP: begin
                if (r_lcur[r_lyr] >= w_span) begin
                    n_lcur[r_lyr] = CW'(r_lcur[r_lyr] - w_span);
                end else if (32'(r_lyr) == LOOP_LAYERS - 1) begin
                    n_voice = '0;
                    n_state = ST_VCHK;
                end else begin
                    n_lyr   = LLW'(r_lyr + LLW'(1));
                    n_state = ST_LCHK;
                end
            end
            ST_VCHK: begin
                if (r_vact[r_voice] && (r_vcur[r_voice] < w_vlen)) begin
                    n_state = ST_VMUL;
                end else begin
                    n_vact[r_voice] = 1'b0;
                    if (32'(r_voice) == VOICE_COUNT - 1) n_state = ST_LM0;
                    else n_voice = VCW'(r_voice + VCW'(1));
                end
            end
            ST_VMUL: n_state = ST_VACC;
            ST_VACC: begin
                n_acc = ACC_W'(r_acc + (ACC_W'(r_prod) <<< 16));
                n_vcur[r_voice] = LW'(r_vcur[r_voice] + LW'(1));
                if (LW'(r_vcur[r_voice] + LW'(1)) >= w_vlen) n_vact[r_voice] = 1'b0;
                if (32'(r_voice) == VOICE_COUNT - 1) begin
                    n_state = ST_LM0;
                end else begin
                    n_voice = VCW'(r_voice + VCW'(1));
                    n_state = ST_VCHK;
                end
            end
            ST_LM0: begin
                n_neg   = r_acc[ACC_W-1];
                n_state = ST_LM1;
            end
            ST_LM1: begin
                n_x     = r_prod[50:16];
                n_state = ST_LM2;
            end
            ST_LM2: begin
                n_sat   = |r_x[34:33];
                n_lo    = (|r_x[34:33]) ? TANH_MAX : tanh_at(r_x[32:29]);
                n_state = ST_LM3;
            end
            ST_LM3: begin
                n_res   = r_neg ? 16'(-w_y) : w_y;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!r_found) begin
                    if (!r_vact[r_voice]) begin
                        n_found = 1'b1;
                        n_pick  = r_voice;
                    end else if (r_vcur[r_voice] >= r_best) begin
                        n_best = r_vcur[r_voice];
                        n_pick = r_voice;
                    end
                end
                if (32'(r_voice) == VOICE_COUNT - 1) n_state = ST_VSET;
                else n_voice = VCW'(r_voice + VCW'(1));
            end
            ST_VSET: begin
                n_vact[r_pick]  = 1'b1;
                n_vclip[r_pick] = r_sclip;
                n_vcur[r_pick]  = '0;
                n_vgain[r_pick] = r_sgain;
                n_state         = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lyr       <= '0;
            r_voice     <= '0;
            r_vact      <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LOOP_LAYERS; l++) begin
                r_lcur[l]  <= '0;
                r_lgain[l] <= '0;
                r_lrate[l] <= UNITY_RATE;
            end
            for (int v = 0; v < VOICE_COUNT; v++) r_vcur[v] <= '0;
            for (int i = 0; i < 4; i++) r_len[i] <= '0;
        end else begin
            r_state     <= n_state;
            r_lyr       <= n_lyr;
            r_voice     <= n_voice;
            r_vact      <= n_vact;
            r_out_valid <= n_out_valid;
            r_lcur      <= n_lcur;
            r_lgain     <= n_lgain;
            r_lrate     <= n_lrate;
            r_vcur      <= n_vcur;
            if (i_cfg_we) r_len[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_tmp      <= n_tmp;
        r_x        <= n_x;
        r_neg      <= n_neg;
        r_sat      <= n_sat;
        r_lo       <= n_lo;
        r_res      <= n_res;
        r_vclip    <= n_vclip;
        r_vgain    <= n_vgain;
        r_sclip    <= n_sclip;
        r_sgain    <= n_sgain;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_out_data <= n_out_data;
        r_prod     <= w_prod;
    end

    // clip memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_sample;
        r_rdata <= r_mem[w_rd_addr];
    end

    a_tick_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (s_axis_tuser == OP_TICK) |=> (r_state == ST_LCHK))
        else $error("tick transaction did not start the mix");

    a_start_claims_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VSET) |=> (r_vact != '0))
        else $error("voice start left no voice active");

    a_limiter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd32746)
                          && ($signed(m_axis_tdata) >= -16'sd32746))
        else $error("limiter output out of range");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && (!r_out_valid || m_axis_tready)
        |=> m_axis_tvalid && (r_state == ST_IDLE))
        else $error("finished sample not presented");

endmodule
